FILE: sv/cbt_pkg.sv
// Shared types, codes and defaults for the circuit breaker table.
package cbt_pkg;

   // default table depth
   localparam int NUM_UPSTREAMS_DEF = 16;

   // field widths
   localparam int UPSTREAM_W  = 4;
   localparam int TIME_W      = 32;
   localparam int THRESH_W    = 16;
   localparam int DURATION_W  = 31;
   localparam int LIMIT_W     = 8;
   localparam int STATE_W     = 2;
   localparam int RUN_W       = 16;
   localparam int INFLIGHT_W  = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 31;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 2'd2;

   // configuration reset values
   localparam logic [THRESH_W-1:0]   THRESHOLD_RST = 16'd5;
   localparam logic [DURATION_W-1:0] DURATION_RST  = 31'd30000;
   localparam logic [LIMIT_W-1:0]    LIMIT_RST     = 8'd1;

   // request action codes
   localparam logic ACT_ADMIT  = 1'b0;
   localparam logic ACT_RECORD = 1'b1;

   // breaker state codes
   localparam logic [STATE_W-1:0] BRK_CLOSED = 2'd0;
   localparam logic [STATE_W-1:0] BRK_OPEN   = 2'd1;
   localparam logic [STATE_W-1:0] BRK_HALF   = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_EXEC
   } fsm_state_type;

   typedef struct packed {
      logic                  action;
      logic [UPSTREAM_W-1:0] upstream;
      logic [TIME_W-1:0]     now_ms;
      logic                  success;
   } cbt_req_type;

   typedef struct packed {
      logic                  admitted;
      logic [STATE_W-1:0]    breaker_state;
      logic [INFLIGHT_W-1:0] tests_in_flight;
   } cbt_rsp_type;

   // one table entry as held in the RAM
   typedef struct packed {
      logic [STATE_W-1:0]    entry_state;
      logic [RUN_W-1:0]      failure_run;
      logic [TIME_W-1:0]     opened_time;
      logic [INFLIGHT_W-1:0] inflight_tests;
   } cbt_entry_type;

   typedef struct packed {
      logic [THRESH_W-1:0]   trip_level;
      logic [DURATION_W-1:0] open_duration;
      logic [LIMIT_W-1:0]    half_open_limit;
   } cbt_cfg_type;

   // write-back from the update logic
   typedef struct packed {
      logic          we;
      cbt_entry_type entry;
   } cbt_upd_type;

endpackage

FILE: sv/cbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/cbt_update.sv
// Read-modify-write logic for one breaker entry: admit and record.
module cbt_update #(
   parameter int NUM_UPSTREAMS = cbt_pkg::NUM_UPSTREAMS_DEF
) (
   input  cbt_pkg::cbt_req_type   req,
   input  cbt_pkg::cbt_entry_type entry_rd,
   input  cbt_pkg::cbt_cfg_type   cfg,
   output cbt_pkg::cbt_upd_type   upd,
   output cbt_pkg::cbt_rsp_type   rsp
);
   import cbt_pkg::*;

   logic              in_range;
   logic              disabled;
   logic              admitted;
   logic [TIME_W-1:0] elapsed;
   logic [RUN_W-1:0]  run_inc;
   logic [INFLIGHT_W-1:0] inflight_dec;
   cbt_entry_type     ne;

   assign in_range = 32'(req.upstream) < 32'(NUM_UPSTREAMS);
   assign disabled = (cfg.trip_level == '0);
   // time since opening, wraps modulo 2^32
   assign elapsed  = req.now_ms - entry_rd.opened_time;
   // saturating counter steps
   assign run_inc  = (entry_rd.failure_run != '1) ? entry_rd.failure_run + 1'b1
                                                  : entry_rd.failure_run;
   assign inflight_dec = (entry_rd.inflight_tests != '0) ?
                         entry_rd.inflight_tests - 1'b1 : entry_rd.inflight_tests;

   // next entry and admit decision
   always_comb begin
      ne       = entry_rd;
      admitted = 1'b0;
      if (req.action == ACT_ADMIT) begin
         if (disabled) begin
            admitted = 1'b1;
         end else begin
            case (entry_rd.entry_state)
               BRK_OPEN: begin
                  if (elapsed >= {1'b0, cfg.open_duration}) begin
                     ne.entry_state    = BRK_HALF;
                     ne.inflight_tests = INFLIGHT_W'(1);
                     admitted          = 1'b1;
                  end
               end
               BRK_HALF: begin
                  if (entry_rd.inflight_tests < cfg.half_open_limit) begin
                     admitted = 1'b1;
                     if (entry_rd.inflight_tests != '1) begin
                        ne.inflight_tests = entry_rd.inflight_tests + 1'b1;
                     end
                  end
               end
               default: begin
                  admitted = 1'b1;
               end
            endcase
         end
      end else if (!disabled) begin
         if (req.success) begin
            ne.failure_run = '0;
            if (entry_rd.entry_state == BRK_HALF) begin
               ne.entry_state    = BRK_CLOSED;
               ne.inflight_tests = inflight_dec;
            end
         end else begin
            ne.failure_run = run_inc;
            if (entry_rd.entry_state == BRK_HALF) begin
               ne.entry_state    = BRK_OPEN;
               ne.opened_time    = req.now_ms;
               ne.inflight_tests = inflight_dec;
            end else if (entry_rd.entry_state == BRK_CLOSED &&
                         run_inc >= cfg.trip_level) begin
               ne.entry_state = BRK_OPEN;
               ne.opened_time = req.now_ms;
            end
         end
      end
   end

   // write-back and result; out-of-range upstream touches nothing
   always_comb begin
      upd.we    = in_range;
      upd.entry = ne;
      if (in_range) begin
         rsp.admitted        = admitted;
         rsp.breaker_state   = ne.entry_state;
         rsp.tests_in_flight = ne.inflight_tests;
      end else begin
         rsp = '0;
      end
   end

endmodule

FILE: sv/circuit_breaker_table.sv
// Circuit breaker table: top level with sequencer, config registers and entry RAM.
// Result path: the entry read is registered at accept, then the EXEC state updates it and registers result and strobe.
// No new item is taken until the current one is written back; busy covers the read-modify-write of the entry.
// The single-port-pair entry RAM sets the order: read, then write-back of the same entry.
// Reset: control and config registers to defaults, then a clearing pass over all NUM_UPSTREAMS entries with busy high.
// Results cannot be stalled by the receiver; each strobe lasts one cycle.
module circuit_breaker_table #(
   parameter int NUM_UPSTREAMS = cbt_pkg::NUM_UPSTREAMS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  cbt_pkg::cbt_req_type                 req_payload,
   output logic                                 rsp_strobe,
   output cbt_pkg::cbt_rsp_type                 rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cbt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cbt_pkg::CSR_DATA_W-1:0]       csr_data
);
   import cbt_pkg::*;

   localparam int IDX_W   = (NUM_UPSTREAMS > 1) ? $clog2(NUM_UPSTREAMS) : 1;
   localparam int ENTRY_W = $bits(cbt_entry_type);

   fsm_state_type state_ff, state_in;
   logic [IDX_W-1:0] clear_cnt_ff, clear_cnt_in;
   cbt_req_type      req_ff;
   cbt_cfg_type      cfg_ff;
   cbt_rsp_type      rsp_ff;
   logic             rsp_strobe_ff;
   logic             accept;
   logic             clear_done;
   logic             rsp_load;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [IDX_W+UPSTREAM_W-1:0] rd_up_wide;
   logic [IDX_W+UPSTREAM_W-1:0] ex_up_wide;
   cbt_entry_type    entry_rd;
   cbt_upd_type      upd;
   cbt_rsp_type      rsp_calc;

   assign accept     = start && !busy;
   assign clear_done = (clear_cnt_ff == IDX_W'(NUM_UPSTREAMS - 1));
   assign csr_ready  = 1'b1;

   // upstream index sized to the RAM address
   assign rd_up_wide = {{IDX_W{1'b0}}, req_payload.upstream};
   assign ex_up_wide = {{IDX_W{1'b0}}, req_ff.upstream};
   assign rd_addr    = rd_up_wide[IDX_W-1:0];
   assign entry_rd   = cbt_entry_type'(rd_data);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: if (clear_done) state_in = FSM_IDLE;
         FSM_IDLE:  if (accept) state_in = FSM_EXEC;
         FSM_EXEC:  state_in = FSM_IDLE;
         default:   state_in = FSM_CLEAR;
      endcase
   end

   // state outputs: busy, RAM write port, result load, clear counter
   always_comb begin
      busy         = 1'b1;
      wr_en        = 1'b0;
      wr_addr      = clear_cnt_ff;
      wr_data      = '0;
      rsp_load     = 1'b0;
      clear_cnt_in = clear_cnt_ff;
      case (state_ff)
         FSM_CLEAR: begin
            wr_en        = 1'b1;
            clear_cnt_in = clear_cnt_ff + 1'b1;
         end
         FSM_IDLE: begin
            busy = 1'b0;
         end
         FSM_EXEC: begin
            wr_en    = upd.we;
            wr_addr  = ex_up_wide[IDX_W-1:0];
            wr_data  = upd.entry;
            rsp_load = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_CLEAR;
         clear_cnt_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_cnt_ff  <= clear_cnt_in;
         rsp_strobe_ff <= rsp_load;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trip_level      <= THRESHOLD_RST;
         cfg_ff.open_duration   <= DURATION_RST;
         cfg_ff.half_open_limit <= LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_ff.trip_level      <= csr_data[THRESH_W-1:0];
            CSR_DURATION:  cfg_ff.open_duration   <= csr_data[DURATION_W-1:0];
            CSR_LIMIT:     cfg_ff.half_open_limit <= csr_data[LIMIT_W-1:0];
            default:       ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   cbt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_UPSTREAMS),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   cbt_update #(
      .NUM_UPSTREAMS(NUM_UPSTREAMS)
   ) u_update (
      .req     (req_ff),
      .entry_rd(entry_rd),
      .cfg     (cfg_ff),
      .upd     (upd),
      .rsp     (rsp_calc)
   );

endmodule

FILE: sv/cbt_checker.sv
// Port-level checks on the circuit breaker table, bound to the top level.
module cbt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe
);

   // reset always enters the clearing pass
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // an accepted item blocks the next one while it is worked on
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // every accepted item gives a result strobe after its update state
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("missing result strobe");

   // no result strobe without a matching accepted item
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without accepted item");

endmodule

bind circuit_breaker_table cbt_checker u_cbt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_strobe(rsp_strobe)
);
